// ===== hw/rtl/zsma_pkg.sv =====
package zsma_pkg;

  localparam int TEMP_W  = 12;
  localparam int HUMID_W = 10;
  localparam int COUNT_W = 4;
  localparam int EVENT_W = 2;

  // largest count the result fields can show
  localparam int COUNT_SAT = 15;

  localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_FIRST  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_UPDATE = 2'd2;

  typedef struct packed {
    logic load;       // shift a good sample in, clear sums
    logic sum_step;   // add oldest entry, rotate histories
    logic div_init;   // set up sign and magnitude for the divide
    logic div_step;   // one quotient bit for both channels
    logic load_out;   // update averages and result word
  } cmd_t;

endpackage

// ===== hw/rtl/zsma_in_if.sv =====
interface zsma_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   sample_ok;
  logic signed [zsma_pkg::TEMP_W-1:0]     temp_sample;
  logic        [zsma_pkg::HUMID_W-1:0]    humid_sample;

  modport source (output valid, output sample_ok, output temp_sample, output humid_sample,
                  input ready);
  modport sink (input valid, input sample_ok, input temp_sample, input humid_sample,
                output ready);
endinterface

// ===== hw/rtl/zsma_out_if.sv =====
interface zsma_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [zsma_pkg::TEMP_W-1:0]     avg_temp;
  logic        [zsma_pkg::HUMID_W-1:0]    avg_humid;
  logic        [zsma_pkg::COUNT_W-1:0]    temp_count;
  logic        [zsma_pkg::COUNT_W-1:0]    humid_count;
  logic        [zsma_pkg::EVENT_W-1:0]    event_code;

  modport source (output valid, output avg_temp, output avg_humid, output temp_count,
                  output humid_count, output event_code, input ready);
  modport sink (input valid, input avg_temp, input avg_humid, input temp_count,
                input humid_count, input event_code, output ready);
endinterface

// ===== hw/rtl/zsma_datapath.sv =====
module zsma_datapath #(
  parameter int N = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  zsma_pkg::cmd_t                      cmd,
  input  logic signed [zsma_pkg::TEMP_W-1:0]  temp_sample,
  input  logic [zsma_pkg::HUMID_W-1:0]        humid_sample,
  output logic signed [zsma_pkg::TEMP_W-1:0]  avg_temp,
  output logic [zsma_pkg::HUMID_W-1:0]        avg_humid,
  output logic [zsma_pkg::COUNT_W-1:0]        temp_count,
  output logic [zsma_pkg::COUNT_W-1:0]        humid_count,
  output logic [zsma_pkg::EVENT_W-1:0]        event_code
);

  localparam int TW = zsma_pkg::TEMP_W;
  localparam int HW = zsma_pkg::HUMID_W;
  localparam int CW = $clog2(N + 1);
  // magnitude of any sum of N entries fits in MW bits
  localparam int MW = TW + CW;

  logic signed [TW-1:0] temp_hist  [N];
  logic        [HW-1:0] humid_hist [N];

  logic signed [MW:0]   tsum;
  logic        [MW-1:0] hsum;
  logic        [CW-1:0] tcnt;
  logic        [CW-1:0] hcnt;

  logic                 tneg;
  logic        [CW-1:0] trem;
  logic        [CW-1:0] hrem;
  logic        [MW-1:0] tquo;
  logic        [MW-1:0] hquo;

  logic signed [TW-1:0] last_temp;
  logic        [HW-1:0] last_humid;

  logic signed [TW-1:0] temp_old;
  logic        [HW-1:0] humid_old;
  logic        [MW:0]   tsum_neg;
  logic        [CW:0]   trem_sh;
  logic        [CW:0]   hrem_sh;
  logic                 tbit;
  logic                 hbit;
  logic        [TW-1:0] tres;

  assign temp_old  = temp_hist[N-1];
  assign humid_old = humid_hist[N-1];
  assign tsum_neg  = -tsum;

  // restoring divide, remainder below the count whenever the count is nonzero
  assign trem_sh = {trem, tquo[MW-1]};
  assign hrem_sh = {hrem, hquo[MW-1]};
  assign tbit    = trem_sh >= {1'b0, tcnt};
  assign hbit    = hrem_sh >= {1'b0, hcnt};
  assign tres    = tneg ? TW'(-tquo[TW-1:0]) : tquo[TW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        temp_hist[i]  <= '0;
        humid_hist[i] <= '0;
      end
    end else if (cmd.load) begin
      temp_hist[0]  <= temp_sample;
      humid_hist[0] <= humid_sample;
      for (int i = 1; i < N; i++) begin
        temp_hist[i]  <= temp_hist[i-1];
        humid_hist[i] <= humid_hist[i-1];
      end
      tsum <= '0;
      hsum <= '0;
      tcnt <= '0;
      hcnt <= '0;
    end else if (cmd.sum_step) begin
      // rotate so the histories are back in place after N steps
      temp_hist[0]  <= temp_old;
      humid_hist[0] <= humid_old;
      for (int i = 1; i < N; i++) begin
        temp_hist[i]  <= temp_hist[i-1];
        humid_hist[i] <= humid_hist[i-1];
      end
      if (temp_old != '0) begin
        tsum <= tsum + {{(MW + 1 - TW){temp_old[TW-1]}}, temp_old};
        tcnt <= tcnt + CW'(1);
      end
      if (humid_old != '0) begin
        hsum <= hsum + {{(MW - HW){1'b0}}, humid_old};
        hcnt <= hcnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      tneg <= tsum[MW];
      tquo <= tsum[MW] ? tsum_neg[MW-1:0] : tsum[MW-1:0];
      hquo <= hsum;
      trem <= '0;
      hrem <= '0;
    end else if (cmd.div_step) begin
      trem <= tbit ? CW'(trem_sh - {1'b0, tcnt}) : trem_sh[CW-1:0];
      hrem <= hbit ? CW'(hrem_sh - {1'b0, hcnt}) : hrem_sh[CW-1:0];
      tquo <= {tquo[MW-2:0], tbit};
      hquo <= {hquo[MW-2:0], hbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_temp  <= '0;
      last_humid <= '0;
    end else if (cmd.load_out) begin
      if (tcnt != '0) begin
        last_temp <= tres;
      end
      if (hcnt != '0) begin
        last_humid <= hquo[HW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      temp_count  <= (32'(tcnt) > zsma_pkg::COUNT_SAT) ?
                     zsma_pkg::COUNT_W'(zsma_pkg::COUNT_SAT) : zsma_pkg::COUNT_W'(tcnt);
      humid_count <= (32'(hcnt) > zsma_pkg::COUNT_SAT) ?
                     zsma_pkg::COUNT_W'(zsma_pkg::COUNT_SAT) : zsma_pkg::COUNT_W'(hcnt);
      if (tcnt == '0) begin
        event_code <= zsma_pkg::EV_NONE;
      end else if (tcnt == CW'(1)) begin
        event_code <= zsma_pkg::EV_FIRST;
      end else begin
        event_code <= zsma_pkg::EV_UPDATE;
      end
    end
  end

  assign avg_temp  = last_temp;
  assign avg_humid = last_humid;

`ifndef NO_ASSERTIONS
  a_tcnt_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (32'(tcnt) <= N && 32'(hcnt) <= N))
    else $error("nonzero count exceeds history depth");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && tcnt != '0) |-> (trem < tcnt))
    else $error("temperature divide remainder not below count");

  a_avg_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.load_out |=> ($stable(last_temp) && $stable(last_humid)))
    else $error("average changed outside an update");
`endif

endmodule

// ===== hw/rtl/zsma_ctrl.sv =====
module zsma_ctrl #(
  parameter int N  = 8,
  parameter int MW = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ok,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output zsma_pkg::cmd_t cmd
);

  localparam int STEPS = (N > MW) ? N : MW;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [2:0] {
    IDLE,
    SUM,
    PREP,
    DIV,
    DONE
  } state_t;

  state_t        state;
  logic [SW-1:0] step;
  logic          out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == IDLE) && in_valid && in_ok;
    cmd.sum_step = (state == SUM);
    cmd.div_init = (state == PREP);
    cmd.div_step = (state == DIV);
    cmd.load_out = (state == DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          step <= '0;
          // a failed read is taken and dropped
          if (in_valid && in_ok) begin
            state <= SUM;
          end
        end
        SUM: begin
          if (step == SW'(N - 1)) begin
            step  <= '0;
            state <= PREP;
          end else begin
            step <= step + SW'(1);
          end
        end
        PREP: begin
          state <= DIV;
        end
        DIV: begin
          if (step == SW'(MW - 1)) begin
            step  <= '0;
            state <= DONE;
          end else begin
            step <= step + SW'(1);
          end
        end
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result word overwritten while waiting");

  a_good_starts_sum: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_ok) |=> (state == SUM && step == '0))
    else $error("good sample did not start accumulation");

  a_bad_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_ok) |=> (state == IDLE))
    else $error("failed read started work");
`endif

endmodule

// ===== hw/rtl/zero_skip_moving_average.sv =====
// Moving average of temperature and humidity over the last HISTORY_DEPTH good
// samples, skipping entries that are zero. A word with sample_ok low is taken
// and dropped with no result. A good word is shifted in at the edge that takes
// it, and its result is then built in order: each history entry is added in
// turn through the accumulators, the divider is set up, one quotient bit per
// cycle for 12 + clog2(HISTORY_DEPTH + 1) bits comes from the restoring
// dividers of both channels, and the output register is loaded once it is
// free; the next word is taken once the result is in the output register.
// Channels with no nonzero entry repeat their previous average.
module zero_skip_moving_average #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  zsma_in_if.sink           samples,
  zsma_out_if.source        results
);

  localparam int MW = zsma_pkg::TEMP_W + $clog2(HISTORY_DEPTH + 1);

  zsma_pkg::cmd_t cmd;

  zsma_ctrl #(
    .N  (HISTORY_DEPTH),
    .MW (MW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ok     (samples.sample_ok),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd)
  );

  zsma_datapath #(
    .N (HISTORY_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .temp_sample  (samples.temp_sample),
    .humid_sample (samples.humid_sample),
    .avg_temp     (results.avg_temp),
    .avg_humid    (results.avg_humid),
    .temp_count   (results.temp_count),
    .humid_count  (results.humid_count),
    .event_code   (results.event_code)
  );

endmodule

// ===== tb/tb_zero_skip_moving_average.sv =====
`timescale 1ns / 1ps

module tb_zero_skip_moving_average;

  localparam int TW = zsma_pkg::TEMP_W;
  localparam int HW = zsma_pkg::HUMID_W;
  localparam int CW = zsma_pkg::COUNT_W;
  localparam int EW = zsma_pkg::EVENT_W;

  localparam int HIST_DEPTH = 8;
  // entries, divider setup, quotient bits and output load
  localparam int WORD_LATENCY = HIST_DEPTH + 14 + $clog2(HIST_DEPTH + 1);
  localparam int RANDOM_WORDS = 1950;

  typedef struct {
    logic signed [TW-1:0] avg_temp;
    logic        [HW-1:0] avg_humid;
    logic        [CW-1:0] temp_count;
    logic        [CW-1:0] humid_count;
    logic        [EW-1:0] event_code;
  } avg_word_t;

  class avg_scoreboard;
    logic signed [TW-1:0] temp_hist [HIST_DEPTH];
    logic        [HW-1:0] humid_hist [HIST_DEPTH];
    logic signed [TW-1:0] temp_mean;
    logic        [HW-1:0] humid_mean;
    avg_word_t            averages_q [$];
    int                   mismatches;

    function new();
      for (int i = 0; i < HIST_DEPTH; i++) begin
        temp_hist[i]  = '0;
        humid_hist[i] = '0;
      end
      temp_mean  = '0;
      humid_mean = '0;
      mismatches = 0;
    endfunction

    function void note_sample(logic ok, logic signed [TW-1:0] t, logic [HW-1:0] h);
      int        tsum;
      int        hsum;
      int        tcnt;
      int        hcnt;
      avg_word_t w;
      tsum = 0;
      hsum = 0;
      tcnt = 0;
      hcnt = 0;
      // failed read leaves the histories alone
      if (!ok) return;
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        temp_hist[i]  = temp_hist[i-1];
        humid_hist[i] = humid_hist[i-1];
      end
      temp_hist[0]  = t;
      humid_hist[0] = h;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        if (temp_hist[i] != 0) begin
          tcnt++;
          tsum += int'(temp_hist[i]);
        end
        if (humid_hist[i] != 0) begin
          hcnt++;
          hsum += int'(humid_hist[i]);
        end
      end
      // int division truncates toward zero
      if (tcnt > 0) temp_mean = TW'(tsum / tcnt);
      if (hcnt > 0) humid_mean = HW'(hsum / hcnt);
      w.avg_temp    = temp_mean;
      w.avg_humid   = humid_mean;
      w.temp_count  = CW'((tcnt > zsma_pkg::COUNT_SAT) ? zsma_pkg::COUNT_SAT : tcnt);
      w.humid_count = CW'((hcnt > zsma_pkg::COUNT_SAT) ? zsma_pkg::COUNT_SAT : hcnt);
      if (tcnt == 0) w.event_code = zsma_pkg::EV_NONE;
      else if (tcnt == 1) w.event_code = zsma_pkg::EV_FIRST;
      else w.event_code = zsma_pkg::EV_UPDATE;
      averages_q.push_back(w);
    endfunction

    function void check_result(avg_word_t got);
      avg_word_t exp;
      if (averages_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: temp %0d humid %0d tcnt %0d hcnt %0d event %0d",
                   got.avg_temp, got.avg_humid, got.temp_count, got.humid_count,
                   got.event_code);
        return;
      end
      exp = averages_q.pop_front();
      if (got.avg_temp !== exp.avg_temp || got.avg_humid !== exp.avg_humid ||
          got.temp_count !== exp.temp_count || got.humid_count !== exp.humid_count ||
          got.event_code !== exp.event_code) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp temp %0d humid %0d tcnt %0d hcnt %0d event %0d",
                   exp.avg_temp, exp.avg_humid, exp.temp_count, exp.humid_count,
                   exp.event_code);
          $display("          got temp %0d humid %0d tcnt %0d hcnt %0d event %0d",
                   got.avg_temp, got.avg_humid, got.temp_count, got.humid_count,
                   got.event_code);
        end
      end
    endfunction

    function int pending();
      return averages_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   no_idle;

  zsma_in_if  in_ch ();
  zsma_out_if out_ch ();

  zero_skip_moving_average #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .samples(in_ch.sink),
    .results(out_ch.source)
  );

  avg_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver side stalls
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    avg_word_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.avg_temp    = out_ch.avg_temp;
      got.avg_humid   = out_ch.avg_humid;
      got.temp_count  = out_ch.temp_count;
      got.humid_count = out_ch.humid_count;
      got.event_code  = out_ch.event_code;
      sb.check_result(got);
    end
  end

  task automatic send_sample(input logic ok, input logic signed [TW-1:0] t,
                             input logic [HW-1:0] h);
    while (!no_idle && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_ok    <= ok;
    in_ch.temp_sample  <= t;
    in_ch.humid_sample <= h;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(ok, t, h);
  endtask

  function automatic logic signed [TW-1:0] pick_temp(bit force_zero);
    int r;
    int v;
    r = $urandom_range(99);
    if (force_zero || r < 12) return '0;
    if (r < 20) return TW'($urandom);
    v = $urandom_range(2160);
    return TW'(v - 400);
  endfunction

  function automatic logic [HW-1:0] pick_humid(bit force_zero);
    int r;
    r = $urandom_range(99);
    if (force_zero || r < 12) return '0;
    if (r < 20) return HW'($urandom);
    return HW'($urandom_range(1000));
  endfunction

  initial begin
    int burst;
    int burst_kind;
    burst      = 0;
    burst_kind = 0;
    no_idle    = 1'b0;
    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.sample_ok    <= 1'b0;
    in_ch.temp_sample  <= '0;
    in_ch.humid_sample <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // failed read before any good one, then all-empty histories
    send_sample(1'b0, 12'sd345, 10'd678);
    send_sample(1'b1, 12'sd0, 10'd0);
    send_sample(1'b1, 12'sd1760, 10'd1000);
    send_sample(1'b1, -12'sd400, 10'd1);
    send_sample(1'b1, -12'sd1, 10'd0);
    send_sample(1'b1, 12'sh800, 10'd1023);
    send_sample(1'b1, 12'sd2047, 10'd512);
    send_sample(1'b0, 12'sd555, 10'd555);
    send_sample(1'b1, -12'sd7, 10'd3);
    send_sample(1'b1, -12'sd1365, 10'd341);
    // flush with zeros so both channels go empty and repeat the last mean
    repeat (HIST_DEPTH) send_sample(1'b1, 12'sd0, 10'd0);
    send_sample(1'b0, -12'sd1, 10'h3ff);
    send_sample(1'b1, -12'sd3, 10'd0);
    send_sample(1'b1, 12'sd0, 10'd7);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      no_idle = (n >= 700 && n < 1000);
      // runs of zeros drain one or both channels
      if (burst == 0 && $urandom_range(99) < 3) begin
        burst      = $urandom_range(HIST_DEPTH + 2, HIST_DEPTH);
        burst_kind = $urandom_range(2);
      end
      if (burst > 0) begin
        burst--;
        send_sample(1'b1, pick_temp(burst_kind != 1), pick_humid(burst_kind != 0));
      end else begin
        send_sample($urandom_range(99) >= 8, pick_temp(1'b0), pick_humid(1'b0));
      end
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (WORD_LATENCY + 10) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
